FILE: design/fractal_gradient_noise_height_macros.svh
// assertion macros for the fractal noise height block
`ifndef FRACTAL_GRADIENT_NOISE_HEIGHT_MACROS_SVH
`define FRACTAL_GRADIENT_NOISE_HEIGHT_MACROS_SVH
`ifndef SYNTHESIS
`define FGN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define FGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define FGN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FGN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/fgnh_pkg.sv
// shared types, constants and functions for the fractal noise height block
`timescale 1ns / 1ps
package fgnh_pkg;
	localparam int GRID_W = 8;
	localparam int FREQ_W = 24;
	localparam int OCT_W = 4;
	localparam int SCALE_W = 8;
	localparam int HEIGHT_W = 17;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
	localparam logic [IDX_W-1:0] REG_BASE_FREQUENCY = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT_GAIN = 2'd2;

	localparam logic [31:0] HASH_KX = 32'd374761393;
	localparam logic [31:0] HASH_KY = 32'd668265263;
	localparam logic [31:0] HASH_KM = 32'd1274126177;

	typedef logic [IDX_W-1:0] cfg_index_t;
	typedef logic [31:0] cfg_data_t;

	typedef struct packed {
		logic [OCT_W-1:0] octave_count;
		logic [FREQ_W-1:0] base_frequency;
		logic [SCALE_W-1:0] height_gain;
	} cfg_regs_t;

	// gradient select: value is +-x +-y on q16 offsets (20-bit signed result)
	function automatic logic signed [19:0] grad_f(input logic [1:0] h,
			input logic signed [17:0] x, input logic signed [17:0] y);
		logic signed [19:0] xe;
		logic signed [19:0] ye;
		xe = 20'(x);
		ye = 20'(y);
		case (h)
			2'd0: grad_f = xe + ye;
			2'd1: grad_f = ye - xe;
			2'd2: grad_f = xe - ye;
			default: grad_f = -xe - ye;
		endcase
	endfunction
endpackage

FILE: design/fgnh_if.sv
// valid/ready channel interfaces for input, result and configuration
`timescale 1ns / 1ps
interface fgnh_in_if;
	logic valid;
	logic ready;
	logic [7:0] grid_x;
	logic [7:0] grid_z;
	modport source (output valid, grid_x, grid_z, input ready);
	modport sink (input valid, grid_x, grid_z, output ready);
endinterface

interface fgnh_out_if;
	logic valid;
	logic ready;
	logic signed [16:0] height;
	modport source (output valid, height, input ready);
	modport sink (input valid, height, output ready);
endinterface

interface fgnh_cfg_if;
	import fgnh_pkg::*;
	logic valid;
	logic ready;
	cfg_index_t index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fgnh_octave.sv
// one octave of 2-d gradient noise as an 8-stage pipeline (s1 to s8)
`timescale 1ns / 1ps
module fgnh_octave #(
	parameter int COORD_BITS = 8,
	parameter int K = 0
) (
	input logic clk,
	input logic en,
	input logic [fgnh_pkg::GRID_W-1:0] gx,
	input logic [fgnh_pkg::GRID_W-1:0] gz,
	input logic [fgnh_pkg::FREQ_W-1:0] freq,
	output logic signed [17:0] noise
);
	import fgnh_pkg::*;

	localparam int CW = GRID_W + FREQ_W + K;

	// s1: coordinates
	logic [CW-1:0] cx_s1, cy_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= CW'(gx) * (CW'(freq) << K);
			cy_s1 <= CW'(gz) * (CW'(freq) << K);
		end
	end

	logic [COORD_BITS-1:0] xi, yi;
	logic [15:0] xf, yf;
	always_comb begin
		xi = COORD_BITS'(cx_s1 >> 24);
		yi = COORD_BITS'(cy_s1 >> 24);
		xf = cx_s1[23:8];
		yf = cy_s1[23:8];
	end

	// s2: hash products and t^2
	logic [31:0] hx0_s2, hx1_s2, hy0_s2, hy1_s2;
	logic [15:0] xf_s2, yf_s2, u2_s2, v2_s2;
	logic [31:0] xsq, ysq;
	assign xsq = 32'(xf) * 32'(xf);
	assign ysq = 32'(yf) * 32'(yf);
	always_ff @(posedge clk) begin
		if (en) begin
			hx0_s2 <= 32'(xi) * HASH_KX;
			hx1_s2 <= (32'(xi) + 32'd1) * HASH_KX;
			hy0_s2 <= 32'(yi) * HASH_KY;
			hy1_s2 <= (32'(yi) + 32'd1) * HASH_KY;
			xf_s2 <= xf;
			yf_s2 <= yf;
			u2_s2 <= xsq[31:16];
			v2_s2 <= ysq[31:16];
		end
	end

	// s3: sum, xor-shift; smoothstep product
	logic [31:0] m_s3 [4];
	logic [15:0] xf_s3, yf_s3, u_s3, v_s3;
	logic [31:0] hs [4];
	logic [35:0] up, vp;
	always_comb begin
		hs[0] = hx0_s2 + hy0_s2;
		hs[1] = hx1_s2 + hy0_s2;
		hs[2] = hx0_s2 + hy1_s2;
		hs[3] = hx1_s2 + hy1_s2;
		up = 36'(u2_s2) * (36'd196608 - 36'({xf_s2, 1'b0}));
		vp = 36'(v2_s2) * (36'd196608 - 36'({yf_s2, 1'b0}));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				m_s3[i] <= hs[i] ^ 32'($signed(hs[i]) >>> 13);
			xf_s3 <= xf_s2;
			yf_s3 <= yf_s2;
			u_s3 <= up[31:16];
			v_s3 <= vp[31:16];
		end
	end

	// s4: final hash multiply, keep low 2 bits only
	logic [1:0] g_s4 [4];
	logic [15:0] xf_s4, yf_s4, u_s4, v_s4;
	logic [31:0] hm [4];
	always_comb begin
		for (int i = 0; i < 4; i++)
			hm[i] = m_s3[i] * HASH_KM;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				g_s4[i] <= hm[i][1:0];
			xf_s4 <= xf_s3;
			yf_s4 <= yf_s3;
			u_s4 <= u_s3;
			v_s4 <= v_s3;
		end
	end

	// s5: gradients (-x-y at the far corner reaches +2.0, hence 20 bits)
	logic signed [19:0] n_s5 [4];
	logic [15:0] u_s5, v_s5;
	logic signed [17:0] x0, y0, x1, y1;
	always_comb begin
		x0 = 18'($signed({2'b00, xf_s4}));
		y0 = 18'($signed({2'b00, yf_s4}));
		x1 = x0 - 18'sd65536;
		y1 = y0 - 18'sd65536;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s5[0] <= grad_f(g_s4[0], x0, y0);
			n_s5[1] <= grad_f(g_s4[1], x1, y0);
			n_s5[2] <= grad_f(g_s4[2], x0, y1);
			n_s5[3] <= grad_f(g_s4[3], x1, y1);
			u_s5 <= u_s4;
			v_s5 <= v_s4;
		end
	end

	// s6: horizontal lerp products
	logic signed [37:0] p0_s6, p1_s6;
	logic signed [19:0] a0_s6, a1_s6;
	logic [15:0] v_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s6 <= 38'(21'(n_s5[1]) - 21'(n_s5[0])) * $signed({22'd0, u_s5});
			p1_s6 <= 38'(21'(n_s5[3]) - 21'(n_s5[2])) * $signed({22'd0, u_s5});
			a0_s6 <= n_s5[0];
			a1_s6 <= n_s5[2];
			v_s6 <= v_s5;
		end
	end

	// s7: horizontal lerp results
	logic signed [19:0] l0_s7, l1_s7;
	logic [15:0] v_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			l0_s7 <= a0_s6 + 20'(p0_s6 >>> 16);
			l1_s7 <= a1_s6 + 20'(p1_s6 >>> 16);
			v_s7 <= v_s6;
		end
	end

	// s8: vertical lerp
	logic signed [38:0] pv;
	assign pv = 39'(21'(l1_s7) - 21'(l0_s7)) * $signed({23'd0, v_s7});
	always_ff @(posedge clk) begin
		if (en)
			noise <= 18'(20'(l0_s7) + 20'(pv >>> 16));
	end
endmodule

FILE: design/fgnh_combine.sv
// octave weighting, sum and height scaling, two register stages
`timescale 1ns / 1ps
module fgnh_combine #(
	parameter int MAX_OCTAVES = 8
) (
	input logic clk,
	input logic en,
	input logic signed [17:0] noise [MAX_OCTAVES],
	input logic [fgnh_pkg::OCT_W-1:0] n_oct,
	input logic [fgnh_pkg::SCALE_W-1:0] scale,
	output logic signed [fgnh_pkg::HEIGHT_W-1:0] height
);
	import fgnh_pkg::*;

	logic signed [21:0] sum;
	logic signed [21:0] sum_s1;
	logic [SCALE_W-1:0] scale_s1;
	always_comb begin
		sum = '0;
		for (int k = 0; k < MAX_OCTAVES; k++)
			if (k < 32'(n_oct))
				sum = sum + 22'(noise[k] >>> k);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum + 22'sd65536;
			scale_s1 <= scale;
		end
	end

	logic signed [31:0] prod;
	logic signed [22:0] h;
	assign prod = 32'(sum_s1) * $signed({24'd0, scale_s1});
	assign h = 23'(prod >>> 9);
	always_ff @(posedge clk) begin
		if (en) begin
			if (h < -23'sd32768)
				height <= -17'sd32768;
			else if (h > 23'sd65535)
				height <= 17'sd65535;
			else
				height <= 17'(h);
		end
	end
endmodule

FILE: design/fractal_gradient_noise_height.sv
// pipeline: 8 octave stages, 2 combine stages and 1 output register from input transaction to result
// throughput: one transaction per cycle while the result channel does not stall; all octaves run as parallel pipelines
// a stall of the result channel freezes the whole pipeline, nothing lost or repeated
// reset: arst_n clears valid bits and restores octave_count 8, base_frequency 167772,
// height gain 80
`timescale 1ns / 1ps
`include "fractal_gradient_noise_height_macros.svh"
module fractal_gradient_noise_height #(
	parameter int COORD_BITS = 8,
	parameter int MAX_OCTAVES = 8
) (
	input logic clk,
	input logic arst_n,
	fgnh_in_if.sink in_ch,
	fgnh_out_if.source out_ch,
	fgnh_cfg_if.sink cfg
);
	import fgnh_pkg::*;

	localparam int DEPTH = 11;

	// configuration registers
	cfg_regs_t cfg_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octave_count <= 4'd8;
			cfg_q.base_frequency <= 24'd167772;
			cfg_q.height_gain <= 8'd80;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OCTAVE_COUNT: cfg_q.octave_count <= cfg.data[OCT_W-1:0];
				REG_BASE_FREQUENCY: cfg_q.base_frequency <= cfg.data[FREQ_W-1:0];
				REG_HEIGHT_GAIN: cfg_q.height_gain <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp octave count to 1..MAX_OCTAVES
	logic [OCT_W-1:0] n_oct;
	always_comb begin
		if (cfg_q.octave_count == '0)
			n_oct = 4'd1;
		else if (32'(cfg_q.octave_count) > MAX_OCTAVES)
			n_oct = OCT_W'(MAX_OCTAVES);
		else
			n_oct = cfg_q.octave_count;
	end

	// pipeline advance: whole chain moves when the output slot is free or taken
	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
	end

	// one noise pipeline per octave
	logic signed [17:0] noise [MAX_OCTAVES];
	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
		fgnh_octave #(.COORD_BITS(COORD_BITS), .K(k)) u_oct (
			.clk(clk),
			.en(en),
			.gx(in_ch.grid_x),
			.gz(in_ch.grid_z),
			.freq(cfg_q.base_frequency),
			.noise(noise[k])
		);
	end

	logic signed [HEIGHT_W-1:0] height_c;
	fgnh_combine #(.MAX_OCTAVES(MAX_OCTAVES)) u_comb (
		.clk(clk),
		.en(en),
		.noise(noise),
		.n_oct(n_oct),
		.scale(cfg_q.height_gain),
		.height(height_c)
	);

	// output register
	logic signed [HEIGHT_W-1:0] height_q;
	always_ff @(posedge clk) begin
		if (en)
			height_q <= height_c;
	end
	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.height = height_q;

	// a stalled result blocks new input transactions
	`FGN_ASSERT_IMPL(a_stall_blocks, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
	// a valid in the second-to-last slot moves to the output when the pipeline advances
	`FGN_ASSERT_NEXT(a_valid_moves, clk, arst_n, en && vld_q[DEPTH-2], out_ch.valid)
	// when the pipeline advances with no input, its front slot holds no valid
	`FGN_ASSERT_NEXT(a_front_empty, clk, arst_n, en && !in_ch.valid, !vld_q[0])
endmodule
